>>> design/srx_pkg.sv
// shared types, codes and constants of the serial frame receiver
package srx_pkg;

	// payload buffer capacity in bytes
	localparam int unsigned BufferBytes = 256;
	localparam logic [16:0] BufferLimit = 17'(BufferBytes);

	// address byte high nibbles
	localparam logic [3:0] KindCommand = 4'h1;
	localparam logic [3:0] KindStatus  = 4'h2;

	// register map: word index of each register
	localparam logic [2:0] RegStartFirst   = 3'd0;
	localparam logic [2:0] RegStartSecond  = 3'd1;
	localparam logic [2:0] RegStartThird   = 3'd2;
	localparam logic [2:0] RegOwnAddress   = 3'd3;
	localparam logic [2:0] RegStatusOpcode = 3'd4;
	localparam logic [2:0] RegStatusSize   = 3'd5;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_START   = 3'd1,
		PH_ADDRESS = 3'd2,
		PH_INSTR   = 3'd3,
		PH_LEN1    = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_GOOD     = 3'd2,
		EV_BAD_SUM  = 3'd3,
		EV_NOT_MINE = 3'd4
	} event_t;

	typedef struct packed {
		logic [7:0]  start_first;
		logic [7:0]  start_second;
		logic [7:0]  start_third;
		logic [3:0]  own_address;
		logic [7:0]  status_opcode;
		logic [15:0] status_size;
	} cfg_t;

endpackage

>>> design/srx_cfg_regs.sv
// configuration register file behind the apb-style port
module srx_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output srx_pkg::cfg_t       cfg
);

	srx_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first   <= 8'h00;
			cfg_q.start_second  <= 8'h00;
			cfg_q.start_third   <= 8'h00;
			cfg_q.own_address   <= 4'h1;
			cfg_q.status_opcode <= 8'h00;
			cfg_q.status_size   <= 16'h0000;
		end else if (wr_en) begin
			unique case (reg_idx)
				srx_pkg::RegStartFirst:   cfg_q.start_first   <= pwdata[7:0];
				srx_pkg::RegStartSecond:  cfg_q.start_second  <= pwdata[7:0];
				srx_pkg::RegStartThird:   cfg_q.start_third   <= pwdata[7:0];
				srx_pkg::RegOwnAddress:   cfg_q.own_address   <= pwdata[3:0];
				srx_pkg::RegStatusOpcode: cfg_q.status_opcode <= pwdata[7:0];
				srx_pkg::RegStatusSize:   cfg_q.status_size   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			srx_pkg::RegStartFirst:   prdata = {24'h0, cfg_q.start_first};
			srx_pkg::RegStartSecond:  prdata = {24'h0, cfg_q.start_second};
			srx_pkg::RegStartThird:   prdata = {24'h0, cfg_q.start_third};
			srx_pkg::RegOwnAddress:   prdata = {28'h0, cfg_q.own_address};
			srx_pkg::RegStatusOpcode: prdata = {24'h0, cfg_q.status_opcode};
			srx_pkg::RegStatusSize:   prdata = {16'h0, cfg_q.status_size};
			default:                  prdata = 32'h0;
		endcase
	end

endmodule

>>> design/serial_frame_receiver_core.sv
// top level of the serial frame receiver: deframer with additive checksum
//
// usage
// - input channel: rx_byte with in_valid/in_ready, one received byte per request
// - output channel: one result request per input byte, event_res plus frame
//   fields, with out_valid/out_ready
// - configuration: apb-style port (pready tied high), six registers at byte
//   addresses 0..20; the user writes them only while the block is idle, which it does not enforce
// - latency: a byte accepted at one edge shows its result in the output
//   register from the next cycle on
// - throughput: one byte per cycle unless the output stalls; the per-byte
//   work is one pass of compares and an 8-bit add between the frame
//   registers and the result register, so nothing loops
// - stall: while a result waits in the output register and out_ready is
//   low, in_ready drops; when out_ready is high a new byte is taken in the
//   same cycle the waiting result leaves
// - reset: arst_n clears the frame state to idle, the two kept bytes to
//   zero, the registers to their defaults, and empties the output register
//
module serial_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [1:0]  msg_kind,
	output logic [7:0]  opcode,
	output logic [15:0] frame_length,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic        fits_buffer,
	output logic        status_hit,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	srx_pkg::cfg_t cfg;

	srx_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// frame state
	srx_pkg::phase_t phase_q, phase_d;
	logic [7:0]  prev_old_q, prev_new_q;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  len_high_q, len_high_d;
	logic [15:0] decl_len_q, decl_len_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [1:0]  kind_q, kind_d;
	logic [7:0]  opcode_q, opcode_d;

	// output register
	logic        out_valid_q;
	srx_pkg::event_t event_q, event_d;
	logic [1:0]  kind_out_q;
	logic [7:0]  opcode_out_q;
	logic [15:0] len_out_q;
	logic [7:0]  pbyte_q, pbyte_d;
	logic [15:0] pidx_q, pidx_d;
	logic        fits_q, fits_d;
	logic        hit_q, hit_d;

	logic fire;
	logic start_hit;
	logic addr_ok;
	logic more_payload;

	// take a byte whenever the output register is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	// start pattern is checked before anything else, in every phase
	assign start_hit = (rx_byte == cfg.start_third) && (prev_new_q == cfg.start_second)
		&& (prev_old_q == cfg.start_first);
	assign addr_ok = (rx_byte == {srx_pkg::KindCommand, cfg.own_address})
		|| (rx_byte == {srx_pkg::KindStatus, cfg.own_address});
	assign more_payload = byte_count_q < decl_len_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (start_hit) begin
			phase_d = srx_pkg::PH_START;
		end else begin
			unique case (phase_q)
				srx_pkg::PH_START:   phase_d = addr_ok ? srx_pkg::PH_ADDRESS : srx_pkg::PH_IDLE;
				srx_pkg::PH_ADDRESS: phase_d = srx_pkg::PH_INSTR;
				srx_pkg::PH_INSTR:   phase_d = srx_pkg::PH_LEN1;
				srx_pkg::PH_LEN1:    phase_d = srx_pkg::PH_PAYLOAD;
				srx_pkg::PH_PAYLOAD: phase_d = more_payload ? srx_pkg::PH_PAYLOAD
					: srx_pkg::PH_IDLE;
				default:             phase_d = srx_pkg::PH_IDLE;
			endcase
		end
	end

	// datapath and result for the byte on the input
	always_comb begin
		sum_d        = sum_q;
		len_high_d   = len_high_q;
		decl_len_d   = decl_len_q;
		byte_count_d = byte_count_q;
		kind_d       = kind_q;
		opcode_d     = opcode_q;
		event_d      = srx_pkg::EV_NONE;
		pbyte_d      = 8'h00;
		pidx_d       = 16'h0000;
		fits_d       = 1'b0;
		hit_d        = 1'b0;
		if (start_hit) begin
			// fresh frame: clear everything gathered so far
			sum_d        = 8'h00;
			len_high_d   = 8'h00;
			decl_len_d   = 16'h0000;
			byte_count_d = 16'h0000;
			kind_d       = 2'd0;
			opcode_d     = 8'h00;
		end else begin
			unique case (phase_q)
				srx_pkg::PH_START: begin
					if (addr_ok) begin
						kind_d = rx_byte[5:4];
					end else begin
						event_d = srx_pkg::EV_NOT_MINE;
					end
					sum_d = sum_q + rx_byte;
				end
				srx_pkg::PH_ADDRESS: begin
					opcode_d = rx_byte;
					sum_d    = sum_q + rx_byte;
				end
				srx_pkg::PH_INSTR: begin
					len_high_d = rx_byte;
					sum_d      = sum_q + rx_byte;
				end
				srx_pkg::PH_LEN1: begin
					decl_len_d   = {len_high_q, rx_byte};
					byte_count_d = 16'h0000;
					sum_d        = sum_q + rx_byte;
				end
				srx_pkg::PH_PAYLOAD: begin
					if (more_payload) begin
						event_d      = srx_pkg::EV_PAYLOAD;
						pbyte_d      = rx_byte;
						pidx_d       = byte_count_q;
						fits_d       = {1'b0, byte_count_q} < srx_pkg::BufferLimit;
						byte_count_d = byte_count_q + 16'd1;
						sum_d        = sum_q + rx_byte;
					end else if (sum_q == rx_byte) begin
						event_d = srx_pkg::EV_GOOD;
						hit_d   = (opcode_q == cfg.status_opcode)
							&& (decl_len_q == cfg.status_size);
					end else begin
						event_d = srx_pkg::EV_BAD_SUM;
					end
				end
				default: ;
			endcase
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= srx_pkg::PH_IDLE;
			prev_old_q   <= 8'h00;
			prev_new_q   <= 8'h00;
			sum_q        <= 8'h00;
			len_high_q   <= 8'h00;
			decl_len_q   <= 16'h0000;
			byte_count_q <= 16'h0000;
			kind_q       <= 2'd0;
			opcode_q     <= 8'h00;
		end else if (fire) begin
			phase_q      <= phase_d;
			prev_old_q   <= prev_new_q;
			prev_new_q   <= rx_byte;
			sum_q        <= sum_d;
			len_high_q   <= len_high_d;
			decl_len_q   <= decl_len_d;
			byte_count_q <= byte_count_d;
			kind_q       <= kind_d;
			opcode_q     <= opcode_d;
		end
	end

	// output valid: set on every accepted byte, cleared when the result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded only with a new byte
	always_ff @(posedge clk) begin
		if (fire) begin
			event_q      <= event_d;
			kind_out_q   <= kind_d;
			opcode_out_q <= opcode_d;
			len_out_q    <= decl_len_d;
			pbyte_q      <= pbyte_d;
			pidx_q       <= pidx_d;
			fits_q       <= fits_d;
			hit_q        <= hit_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = event_q;
	assign msg_kind      = kind_out_q;
	assign opcode        = opcode_out_q;
	assign frame_length  = len_out_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pidx_q;
	assign fits_buffer   = fits_q;
	assign status_hit    = hit_q;

	// a start pattern always lands in the start phase
	a_start_wins: assert property (@(posedge clk) disable iff (!arst_n)
		fire && start_hit |=> phase_q == srx_pkg::PH_START)
		else $error("start pattern did not restart framing");

	// each reported payload byte advances the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (event_d == srx_pkg::EV_PAYLOAD) |=> byte_count_q == $past(byte_count_q) + 16'd1)
		else $error("payload count did not advance");

	// payload fields stay zero outside payload results
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q != srx_pkg::EV_PAYLOAD)
		|-> (pidx_q == 16'h0000) && (pbyte_q == 8'h00) && !fits_q)
		else $error("payload fields set on a non-payload result");

	// a frame verdict always ends the frame
	a_verdict_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ((event_d == srx_pkg::EV_GOOD) || (event_d == srx_pkg::EV_BAD_SUM))
		|=> phase_q == srx_pkg::PH_IDLE)
		else $error("frame did not end after checksum byte");

endmodule
